// File: src/ple_pkg.sv
package ple_pkg;

  localparam int DEPTH = 16;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = 5;
  localparam int VW    = 32;

  typedef enum logic [2:0] {
    OP_DUMP_ALL = 3'd0,
    OP_DUMP_TO  = 3'd1,
    OP_INSERT   = 3'd2,
    OP_DELETE   = 3'd3,
    OP_SEARCH   = 3'd4
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_BADPOS   = 3'd2,
    ST_FULL     = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  typedef struct packed {
    logic          we;
    logic [AW-1:0] waddr;
    logic [VW-1:0] wdata;
    logic          re;
    logic [AW-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic          push;
    status_t       status;
    logic [VW-1:0] value;
    logic [CW-1:0] pos;
    logic          last;
  } result_t;

endpackage

// File: src/ple_ram.sv
module ple_ram
  import ple_pkg::*;
(
  input  logic          clk,
  input  mem_req_t      req,
  output logic [VW-1:0] rd_data
);

  logic [VW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_data <= mem[req.raddr];
    end
  end

endmodule

// File: src/ple_ctrl.sv
module ple_ctrl
  import ple_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_take,
  input  logic [2:0]    opcode,
  input  logic [VW-1:0] item_value,
  input  logic [CW-1:0] position,
  input  logic          out_busy,
  input  logic [VW-1:0] rd_data,
  output mem_req_t      mem,
  output result_t       res,
  output logic [CW-1:0] count,
  output logic          idle
);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_DUMP     = 9'b000000010,
    S_SRCH     = 9'b000000100,
    S_SRCH_END = 9'b000001000,
    S_INS      = 9'b000010000,
    S_INS_FIN  = 9'b000100000,
    S_DEL_GONE = 9'b001000000,
    S_DEL      = 9'b010000000,
    S_EMIT     = 9'b100000000
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] limit_r, limit_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic [VW-1:0] val_r, val_nxt;
  logic          pend_r, pend_nxt;
  logic [CW-1:0] pend_pos_r, pend_pos_nxt;
  status_t       rstat_r, rstat_nxt;
  logic [VW-1:0] rval_r, rval_nxt;
  logic [CW-1:0] rpos_r, rpos_nxt;

  logic          can_push;
  logic [CW-1:0] idx_p1;
  logic [CW:0]   cnt_p1;
  logic [CW-1:0] del_pos;
  logic          match;

  assign can_push = !out_busy;
  assign idx_p1   = CW'(idx_r) + 1'b1;
  assign cnt_p1   = {1'b0, count_r} + 1'b1;
  assign del_pos  = (count_r == CW'(1)) ? CW'(1) : position;
  assign match    = (rd_data == val_r);

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    idx_nxt      = idx_r;
    limit_nxt    = limit_r;
    pos_nxt      = pos_r;
    val_nxt      = val_r;
    pend_nxt     = pend_r;
    pend_pos_nxt = pend_pos_r;
    rstat_nxt    = rstat_r;
    rval_nxt     = rval_r;
    rpos_nxt     = rpos_r;
    mem          = '0;
    res          = '0;
    res.status   = ST_OK;

    unique case (state_r)
      S_IDLE: begin
        if (in_take) begin
          rval_nxt = '0;
          rpos_nxt = '0;
          unique case (opcode) inside
            OP_DUMP_ALL, OP_DUMP_TO: begin
              if (count_r == '0) begin
                rstat_nxt = ST_EMPTY;
                state_nxt = S_EMIT;
              end else if (opcode == OP_DUMP_TO &&
                           (position == '0 || position > count_r)) begin
                rstat_nxt = ST_BADPOS;
                state_nxt = S_EMIT;
              end else begin
                limit_nxt = (opcode == OP_DUMP_ALL) ? count_r : position;
                idx_nxt   = '0;
                mem.re    = 1'b1;
                mem.raddr = '0;
                state_nxt = S_DUMP;
              end
            end
            OP_INSERT: begin
              val_nxt = item_value;
              if (count_r == '0) begin
                pos_nxt   = CW'(1);
                state_nxt = S_INS_FIN;
              end else if (count_r >= CW'(DEPTH)) begin
                rstat_nxt = ST_FULL;
                state_nxt = S_EMIT;
              end else if (position == '0 || {1'b0, position} > cnt_p1) begin
                rstat_nxt = ST_BADPOS;
                state_nxt = S_EMIT;
              end else begin
                pos_nxt = position;
                if (position <= count_r) begin
                  // shift tail down one slot, starting from the last entry
                  idx_nxt   = AW'(count_r - 1'b1);
                  mem.re    = 1'b1;
                  mem.raddr = AW'(count_r - 1'b1);
                  state_nxt = S_INS;
                end else begin
                  state_nxt = S_INS_FIN;
                end
              end
            end
            OP_DELETE: begin
              if (count_r == '0) begin
                rstat_nxt = ST_EMPTY;
                state_nxt = S_EMIT;
              end else if (del_pos == '0 || del_pos > count_r) begin
                rstat_nxt = ST_BADPOS;
                state_nxt = S_EMIT;
              end else begin
                pos_nxt   = del_pos;
                mem.re    = 1'b1;
                mem.raddr = AW'(del_pos - 1'b1);
                state_nxt = S_DEL_GONE;
              end
            end
            OP_SEARCH: begin
              if (count_r == '0) begin
                rstat_nxt = ST_EMPTY;
                state_nxt = S_EMIT;
              end else begin
                val_nxt   = item_value;
                limit_nxt = count_r;
                pend_nxt  = 1'b0;
                idx_nxt   = '0;
                mem.re    = 1'b1;
                mem.raddr = '0;
                state_nxt = S_SRCH;
              end
            end
            default: ;
          endcase
        end
      end

      S_DUMP: begin
        if (can_push) begin
          res.push   = 1'b1;
          res.value  = rd_data;
          res.pos    = idx_p1;
          res.last   = (idx_p1 == limit_r);
          if (idx_p1 == limit_r) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = AW'(idx_p1);
            mem.re    = 1'b1;
            mem.raddr = AW'(idx_p1);
          end
        end
      end

      // a match is held back one step so the final one can carry last
      S_SRCH: begin
        if (!(match && pend_r && !can_push)) begin
          if (match && pend_r) begin
            res.push  = 1'b1;
            res.value = val_r;
            res.pos   = pend_pos_r;
          end
          if (match) begin
            pend_nxt     = 1'b1;
            pend_pos_nxt = idx_p1;
          end
          if (idx_p1 == limit_r) begin
            state_nxt = S_SRCH_END;
          end else begin
            idx_nxt   = AW'(idx_p1);
            mem.re    = 1'b1;
            mem.raddr = AW'(idx_p1);
          end
        end
      end

      S_SRCH_END: begin
        if (can_push) begin
          res.push   = 1'b1;
          res.value  = val_r;
          res.last   = 1'b1;
          res.pos    = pend_r ? pend_pos_r : '0;
          res.status = pend_r ? ST_OK : ST_NOTFOUND;
          state_nxt  = S_IDLE;
        end
      end

      S_INS: begin
        mem.we    = 1'b1;
        mem.waddr = AW'(idx_p1);
        mem.wdata = rd_data;
        if (idx_p1 == pos_r) begin
          state_nxt = S_INS_FIN;
        end else begin
          idx_nxt   = idx_r - 1'b1;
          mem.re    = 1'b1;
          mem.raddr = idx_r - 1'b1;
        end
      end

      S_INS_FIN: begin
        mem.we    = 1'b1;
        mem.waddr = AW'(pos_r - 1'b1);
        mem.wdata = val_r;
        count_nxt = count_r + 1'b1;
        rstat_nxt = ST_OK;
        rval_nxt  = val_r;
        rpos_nxt  = pos_r;
        state_nxt = S_EMIT;
      end

      S_DEL_GONE: begin
        rstat_nxt = ST_OK;
        rval_nxt  = rd_data;
        rpos_nxt  = pos_r;
        if (pos_r == count_r) begin
          count_nxt = count_r - 1'b1;
          state_nxt = S_EMIT;
        end else begin
          idx_nxt   = AW'(pos_r);
          mem.re    = 1'b1;
          mem.raddr = AW'(pos_r);
          state_nxt = S_DEL;
        end
      end

      S_DEL: begin
        mem.we    = 1'b1;
        mem.waddr = idx_r - 1'b1;
        mem.wdata = rd_data;
        if (idx_p1 == count_r) begin
          count_nxt = count_r - 1'b1;
          state_nxt = S_EMIT;
        end else begin
          idx_nxt   = AW'(idx_p1);
          mem.re    = 1'b1;
          mem.raddr = AW'(idx_p1);
        end
      end

      S_EMIT: begin
        if (can_push) begin
          res.push   = 1'b1;
          res.status = rstat_r;
          res.value  = rval_r;
          res.pos    = rpos_r;
          res.last   = 1'b1;
          state_nxt  = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    limit_r    <= limit_nxt;
    pos_r      <= pos_nxt;
    val_r      <= val_nxt;
    pend_pos_r <= pend_pos_nxt;
    rstat_r    <= rstat_nxt;
    rval_r     <= rval_nxt;
    rpos_r     <= rpos_nxt;
  end

  assign count = count_r;
  assign idle  = (state_r == S_IDLE);

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count beyond depth");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    res.push |-> !out_busy)
    else $error("result pushed into a stalled output register");

  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !mem.we)
    else $error("list memory written while idle");

  a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && (count_r != $past(count_r)) |->
      (count_r == $past(count_r) + 1'b1) || (count_r == $past(count_r) - 1'b1))
    else $error("entry count moved by more than one");

endmodule

// File: src/positional_list_engine_core.sv
// Channel  Handshake             Payload
// in       in_valid / in_stall   in_opcode, in_item_value, in_position
// out      out_valid / out_stall out_status, out_value, out_position,
//                                out_entry_count, out_last
//
// Dump: a memory read, then one entry per cycle while the output is not stalled.
// Search: a pass over the whole list as in a dump, then a final state for the last result.
// Insert shifts the tail down from the last entry, then writes the new value; delete
//   reads the entry that goes, then shifts the tail up. Errors go straight to the reply.
// Synchronous reset empties the list; no clearing pass is needed.
// in_stall is high while a command is in progress; a stalled output holds.
module positional_list_engine_core
  import ple_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [2:0]           in_opcode,
  input  logic signed [VW-1:0] in_item_value,
  input  logic [CW-1:0]        in_position,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [2:0]           out_status,
  output logic signed [VW-1:0] out_value,
  output logic [CW-1:0]        out_position,
  output logic [CW-1:0]        out_entry_count,
  output logic                 out_last
);

  mem_req_t      mem;
  result_t       res;
  logic [VW-1:0] rd_data;
  logic [CW-1:0] count;
  logic          idle;
  logic          out_busy;

  logic          out_valid_r;
  logic [2:0]    status_r;
  logic [VW-1:0] value_r;
  logic [CW-1:0] pos_r;
  logic [CW-1:0] ecount_r;
  logic          last_r;

  assign in_stall = !idle;
  assign out_busy = out_valid_r && out_stall;

  ple_ram u_ram (
    .clk     (clk),
    .req     (mem),
    .rd_data (rd_data)
  );

  ple_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_take    (in_valid && !in_stall),
    .opcode     (in_opcode),
    .item_value (in_item_value),
    .position   (in_position),
    .out_busy   (out_busy),
    .rd_data    (rd_data),
    .mem        (mem),
    .res        (res),
    .count      (count),
    .idle       (idle)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.push) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // count is already final when the result leaves the controller
  always_ff @(posedge clk) begin
    if (res.push) begin
      status_r <= res.status;
      value_r  <= res.value;
      pos_r    <= res.pos;
      ecount_r <= count;
      last_r   <= res.last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_value       = value_r;
  assign out_position    = pos_r;
  assign out_entry_count = ecount_r;
  assign out_last        = last_r;

endmodule

// File: sim/positional_list_engine_core_tb.sv
module positional_list_engine_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ple_pkg::*;

  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 3 * DEPTH;

  typedef struct {
    status_t       status;
    logic [VW-1:0] value;
    logic [CW-1:0] position;
    logic [CW-1:0] count;
    logic          last;
  } list_reply_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [2:0]           in_opcode = '0;
  logic signed [VW-1:0] in_item_value = '0;
  logic [CW-1:0]        in_position = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [2:0]           out_status;
  logic signed [VW-1:0] out_value;
  logic [CW-1:0]        out_position;
  logic [CW-1:0]        out_entry_count;
  logic                 out_last;

  // predicted list contents and replies still owed by the block
  logic [VW-1:0] list_model [DEPTH];
  int            list_len = 0;
  int            peak_len = 0;
  list_reply_t   pending_replies [$];
  logic [VW-1:0] value_pool [4];

  int gap_pct = 0;
  int stall_pct = 0;
  int hold_requests = 0;
  int holds_served = 0;
  int hold_left = 0;
  int cycle_count = 0;
  int error_count = 0;
  int commands_sent = 0;
  int ignored_sent = 0;
  int replies_seen = 0;

  positional_list_engine_core u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_item_value   (in_item_value),
    .in_position     (in_position),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_value       (out_value),
    .out_position    (out_position),
    .out_entry_count (out_entry_count),
    .out_last        (out_last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles, %0d replies outstanding",
               cycle_count, pending_replies.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver: random stall, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_requests != holds_served) begin
      out_stall    <= 1'b1;
      hold_left    <= HOLD_CYCLES;
      holds_served <= hold_requests;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  function automatic void check_field(string name, logic [VW-1:0] want, logic [VW-1:0] got);
    if (got !== want) begin
      $error("%s expected %0h got %0h", name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin : reply_check
    list_reply_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_replies.size() == 0) begin
        $error("unexpected transfer: status %0d value %0h position %0d",
               out_status, out_value, out_position);
        error_count++;
      end else begin
        want = pending_replies.pop_front();
        check_field("out_status", VW'(want.status), VW'(out_status));
        check_field("out_value", want.value, out_value);
        check_field("out_position", VW'(want.position), VW'(out_position));
        check_field("out_entry_count", VW'(want.count), VW'(out_entry_count));
        check_field("out_last", VW'(want.last), VW'(out_last));
        replies_seen++;
      end
    end
  end

  function automatic void push_reply(status_t st, logic [VW-1:0] v, int p, logic fin);
    list_reply_t r;
    r.status   = st;
    r.value    = v;
    r.position = CW'(p);
    r.count    = CW'(list_len);
    r.last     = fin;
    pending_replies.push_back(r);
  endfunction

  function automatic void push_range(int upto);
    for (int i = 0; i < upto; i++)
      push_reply(ST_OK, list_model[i], i + 1, i + 1 == upto);
  endfunction

  function automatic void predict_command(logic [2:0] op, logic [VW-1:0] val, int pos);
    int n;
    int hits;
    logic [VW-1:0] gone;
    n = list_len;
    case (op)
      OP_DUMP_ALL: begin
        if (n == 0) push_reply(ST_EMPTY, '0, 0, 1'b1);
        else push_range(n);
      end
      OP_DUMP_TO: begin
        if (n == 0) push_reply(ST_EMPTY, '0, 0, 1'b1);
        else if (pos < 1 || pos > n) push_reply(ST_BADPOS, '0, 0, 1'b1);
        else push_range(pos);
      end
      OP_INSERT: begin
        if (n == 0) begin
          list_model[0] = val;
          list_len = 1;
          push_reply(ST_OK, val, 1, 1'b1);
        end else if (n >= DEPTH) begin
          push_reply(ST_FULL, '0, 0, 1'b1);
        end else if (pos < 1 || pos > n + 1) begin
          push_reply(ST_BADPOS, '0, 0, 1'b1);
        end else begin
          for (int i = n; i >= pos; i--)
            list_model[i] = list_model[i - 1];
          list_model[pos - 1] = val;
          list_len = n + 1;
          push_reply(ST_OK, val, pos, 1'b1);
        end
      end
      OP_DELETE: begin
        if (n == 1) pos = 1;  // sole entry goes whatever position is asked
        if (n == 0) begin
          push_reply(ST_EMPTY, '0, 0, 1'b1);
        end else if (pos < 1 || pos > n) begin
          push_reply(ST_BADPOS, '0, 0, 1'b1);
        end else begin
          gone = list_model[pos - 1];
          for (int i = pos; i < n; i++)
            list_model[i - 1] = list_model[i];
          list_len = n - 1;
          push_reply(ST_OK, gone, pos, 1'b1);
        end
      end
      OP_SEARCH: begin
        if (n == 0) begin
          push_reply(ST_EMPTY, '0, 0, 1'b1);
        end else begin
          hits = 0;
          for (int i = 0; i < n; i++) begin
            if (list_model[i] == val) begin
              push_reply(ST_OK, val, i + 1, 1'b0);
              hits++;
            end
          end
          if (hits == 0) push_reply(ST_NOTFOUND, val, 0, 1'b1);
          else pending_replies[pending_replies.size() - 1].last = 1'b1;
        end
      end
      default: ;  // spare opcodes leave the list alone and answer nothing
    endcase
    if (list_len > peak_len) peak_len = list_len;
  endfunction

  task automatic send_command(input logic [2:0] op, input logic [VW-1:0] val,
                              input logic [CW-1:0] pos);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_opcode     <= op;
    in_item_value <= val;
    in_position   <= pos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_command(op, val, pos);
    if (op > OP_SEARCH) ignored_sent++;
    else commands_sent++;
  endtask

  task automatic pause_sender();
    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  function automatic logic [VW-1:0] pick_value();
    if ($urandom_range(1) == 0) return value_pool[$urandom_range(3)];
    return $urandom;
  endfunction

  function automatic logic [CW-1:0] pick_position(int top);
    if (top > 0 && $urandom_range(99) < 85) return CW'($urandom_range(top, 1));
    return CW'($urandom_range(31));
  endfunction

  task automatic test_empty_list();
    send_command(OP_DUMP_ALL, '0, 5'd0);
    send_command(OP_DUMP_TO, '0, 5'd1);
    send_command(OP_DELETE, '0, 5'd1);
    send_command(OP_SEARCH, 32'hffff_ffff, 5'd0);
  endtask

  task automatic test_single_entry();
    send_command(OP_INSERT, 32'h8000_0000, 5'd31);  // position ignored when empty
    send_command(OP_DELETE, '0, 5'd0);              // position ignored with one entry
    send_command(OP_INSERT, 32'h7fff_ffff, 5'd0);
  endtask

  task automatic test_positions();
    send_command(OP_INSERT, 32'h1234_5678, 5'd0);
    send_command(OP_INSERT, 32'h1234_5678, 5'd3);
    send_command(OP_INSERT, 32'hffff_ffff, 5'd2);
    send_command(OP_INSERT, 32'h0000_0000, 5'd1);
    send_command(OP_DUMP_TO, '0, 5'd0);
    send_command(OP_DUMP_TO, '0, 5'd4);
    send_command(OP_DUMP_TO, '0, 5'd3);
    send_command(OP_DELETE, '0, 5'd0);
    send_command(OP_DELETE, '0, 5'd4);
    send_command(OP_DELETE, '0, 5'd2);
    send_command(OP_INSERT, 32'h0000_0000, 5'd3);
    send_command(OP_SEARCH, 32'h0000_0000, 5'd0);
    send_command(OP_SEARCH, 32'h5a5a_a5a5, 5'd0);
    send_command(OP_DUMP_ALL, '0, 5'd0);
  endtask

  task automatic test_spare_opcodes();
    for (int c = int'(OP_SEARCH) + 1; c < 8; c++)
      send_command(3'(c), $urandom, CW'($urandom_range(31)));
  endtask

  // fill to DEPTH, poke the full-list corners, then send more with the output blocked
  task automatic test_full_list();
    while (list_len < DEPTH)
      send_command(OP_INSERT, pick_value(), CW'($urandom_range(list_len + 1, 1)));
    send_command(OP_INSERT, $urandom, CW'(DEPTH));
    send_command(OP_SEARCH, list_model[DEPTH - 1], 5'd0);
    send_command(OP_DUMP_TO, '0, CW'(DEPTH));
    send_command(OP_DUMP_TO, '0, CW'(DEPTH + 1));
    pause_sender();
    hold_requests <= hold_requests + 1;
    send_command(OP_DUMP_ALL, '0, 5'd0);
    send_command(OP_DUMP_ALL, '0, 5'd0);
    send_command(OP_SEARCH, list_model[0], 5'd0);
    send_command(OP_DELETE, '0, CW'(DEPTH));
    send_command(OP_INSERT, 32'h8000_0000, CW'(DEPTH + 1));
    send_command(OP_INSERT, 32'h8000_0000, CW'(DEPTH));
    pause_sender();
  endtask

  task automatic test_random_traffic(input int n_items, input int gap, input int stall);
    int done;
    int k;
    int ins_w;
    int del_w;
    logic [VW-1:0] v;
    gap_pct   = gap;
    stall_pct <= stall;
    done = 0;
    while (done < n_items) begin
      if ($urandom_range(99) < 4) begin
        send_command(3'(int'(OP_SEARCH) + 1 + $urandom_range(2)), $urandom,
                     CW'($urandom_range(31)));
      end else begin
        k     = $urandom_range(99);
        ins_w = (list_len < DEPTH - 3) ? 40 : 15;
        del_w = (list_len > 3) ? 30 : 10;
        if (k < ins_w) begin
          send_command(OP_INSERT, pick_value(), pick_position(list_len + 1));
        end else if (k < ins_w + del_w) begin
          send_command(OP_DELETE, '0, pick_position(list_len));
        end else if (k < ins_w + del_w + 10) begin
          send_command(OP_DUMP_ALL, $urandom, CW'($urandom_range(31)));
        end else if (k < ins_w + del_w + 20) begin
          send_command(OP_DUMP_TO, $urandom, pick_position(list_len));
        end else begin
          if (list_len > 0 && $urandom_range(99) < 60)
            v = list_model[$urandom_range(list_len - 1)];
          else
            v = pick_value();
          send_command(OP_SEARCH, v, CW'($urandom_range(31)));
        end
        done++;
      end
    end
    pause_sender();
  endtask

  initial begin
    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7fff_ffff;
    value_pool[2] = $urandom;
    value_pool[3] = $urandom;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_list();
    test_single_entry();
    test_positions();
    test_spare_opcodes();
    test_full_list();
    test_random_traffic(30, 0, 0);
    test_random_traffic(30, 51, 0);
    test_random_traffic(30, 0, 51);
    test_random_traffic(30, 38, 38);

    gap_pct   = 0;
    stall_pct <= 0;
    pause_sender();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d commands and %0d spare opcodes, checked %0d transfers.",
             commands_sent, ignored_sent, replies_seen);
    $display("List reached %0d entries; empty, full, bad position and miss cases hit.",
             peak_len);
    if (error_count == 0 && pending_replies.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
